// File: hw/rtl/ise_pkg.sv
// Shared constants and codes for the interval set engine.
`default_nettype none
package ise_pkg;
    localparam int MAX_RANGES_DEF = 64;
    localparam int CODE_BITS_DEF  = 21;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_COMPARE = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic [2:0] REL_DISJOINT = 3'd0;
    localparam logic [2:0] REL_OVERLAP  = 3'd1;
    localparam logic [2:0] REL_SUPERSET = 3'd2;
    localparam logic [2:0] REL_SUBSET   = 3'd3;
    localparam logic [2:0] REL_EQUIV    = 3'd4;
endpackage
`default_nettype wire

// File: hw/rtl/interval_set_engine_top.sv
// Top level of the interval set engine: two sorted range sets with insert, remove, compare.
//
// Usage:
//   Commands enter on the s_ stream; s_tready is high only while the engine is idle.
//   Each command yields exactly one result transfer on the m_ stream.
//   Insert and remove walk the selected set through one read port of the range
//   memory one stored range at a time, build the new list in a scratch memory
//   and copy it back one range at a time.
//   A command that would overflow MAX_RANGES skips the copy and reports full_error.
//   Compare walks both sets through the same read port. A reversed insert or
//   remove range, or an unused command, goes straight to the final state.
//   The shared range memory read port paces the walks of the stored sets.
//   Reset empties both sets (counts to zero, stored entries are never read
//   before being written) and drops any pending result.
//   A finished result is held in the output register until m_tready; the next
//   command is accepted meanwhile, and its result waits in the final state
//   until the output register frees.
`default_nettype none
module interval_set_engine_top #(
    parameter int MAX_RANGES = ise_pkg::MAX_RANGES_DEF,
    parameter int CODE_BITS  = ise_pkg::CODE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // cmd[1:0], set_sel[2], lo_code[23:3], hi_code[44:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // relation[2:0], full_error[3], range_count[10:4]
);
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int CB = CODE_BITS;
    localparam int AW = IW + 1;
    localparam int DW = 2 * CB;
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_WRD  = 12'b000000000010,
        S_WEX  = 12'b000000000100,
        S_KRD  = 12'b000000001000,
        S_KWR  = 12'b000000010000,
        S_CCK  = 12'b000000100000,
        S_CFA  = 12'b000001000000,
        S_CWA  = 12'b000010000000,
        S_CFB  = 12'b000100000000,
        S_CWB  = 12'b001000000000,
        S_CEV  = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

    logic [DW-1:0] smem [2*MAX_RANGES];
    logic [DW-1:0] scr  [MAX_RANGES];
    logic [DW-1:0] r_smem_q, r_scr_q;

    t_state        r_state, n_state;
    logic          r_is_rem, n_is_rem, r_sel, n_sel;
    logic [CB-1:0] r_lo, n_lo, r_hi, n_hi, r_nlo, n_nlo, r_nhi, n_nhi;
    logic [CW-1:0] r_i, n_i, r_n, n_n, r_k, n_k, r_ia, n_ia, r_ib, n_ib;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic          r_ovf, n_ovf, r_emitted, n_emitted, r_sub, n_sub;
    logic          r_need_a, n_need_a, r_need_b, n_need_b;
    logic [CB-1:0] r_al, n_al, r_ah, n_ah, r_bl, n_bl, r_bh, n_bh;
    logic          r_nsub, n_nsub, r_nsup, n_nsup, r_disj, n_disj;
    logic [2:0]    r_rel, n_rel;
    logic          r_full, n_full;
    logic          r_ovalid, n_ovalid;
    logic [15:0]   r_odata, n_odata;

    logic          smem_re, smem_we, scr_re, scr_we, emit;
    logic [AW-1:0] smem_ra, smem_wa;
    logic [IW-1:0] scr_ra;
    logic [DW-1:0] smem_wd, emit_d;
    logic [CW-1:0] cur_n;
    logic [1:0]    in_cmd;
    logic [CB-1:0] in_lo, in_hi, e_lo, e_hi;
    logic          nsub_f, nsup_f;

    always_ff @(posedge i_clk) begin
        if (smem_we) smem[smem_wa] <= smem_wd;
        if (smem_re) r_smem_q <= smem[smem_ra];
        if (scr_we) scr[r_n[IW-1:0]] <= emit_d;
        if (scr_re) r_scr_q <= scr[scr_ra];
    end

    assign cur_n  = r_sel ? r_cnt_b : r_cnt_a;
    assign in_cmd = s_tdata[1:0];
    assign in_lo  = CB'(s_tdata[23:3]);
    assign in_hi  = CB'(s_tdata[44:24]);
    assign e_lo   = r_smem_q[DW-1:CB];
    assign e_hi   = r_smem_q[CB-1:0];
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    always_comb begin
        n_state = r_state; n_is_rem = r_is_rem; n_sel = r_sel; n_lo = r_lo; n_hi = r_hi;
        n_nlo = r_nlo; n_nhi = r_nhi; n_i = r_i; n_n = r_n; n_k = r_k; n_ia = r_ia;
        n_ib = r_ib; n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b; n_ovf = r_ovf;
        n_emitted = r_emitted; n_sub = r_sub; n_need_a = r_need_a; n_need_b = r_need_b;
        n_al = r_al; n_ah = r_ah; n_bl = r_bl; n_bh = r_bh; n_nsub = r_nsub;
        n_nsup = r_nsup; n_disj = r_disj; n_rel = r_rel; n_full = r_full;
        n_ovalid = r_ovalid; n_odata = r_odata;
        smem_re = 1'b0; smem_we = 1'b0; scr_re = 1'b0; scr_we = 1'b0; emit = 1'b0;
        smem_ra = '0; smem_wa = '0; smem_wd = r_scr_q; scr_ra = r_k[IW-1:0];
        emit_d = r_smem_q; nsub_f = r_nsub; nsup_f = r_nsup;
        if (r_ovalid && m_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_sel = s_tdata[2]; n_lo = in_lo; n_hi = in_hi;
                    n_nlo = in_lo; n_nhi = in_hi;
                    n_is_rem = (in_cmd == ise_pkg::CMD_REMOVE);
                    n_i = '0; n_n = '0; n_k = '0; n_ia = '0; n_ib = '0;
                    n_ovf = 1'b0; n_emitted = 1'b0; n_sub = 1'b0;
                    n_need_a = 1'b1; n_need_b = 1'b1;
                    n_nsub = 1'b0; n_nsup = 1'b0; n_disj = 1'b1;
                    n_rel = ise_pkg::REL_DISJOINT; n_full = 1'b0;
                    if ((in_cmd == ise_pkg::CMD_INSERT || in_cmd == ise_pkg::CMD_REMOVE)
                        && in_lo <= in_hi) n_state = S_WRD;
                    else if (in_cmd == ise_pkg::CMD_COMPARE) n_state = S_CCK;
                    else n_state = S_DONE;
                end
            end
            S_WRD: begin
                if (r_i < cur_n) begin
                    smem_re = 1'b1; smem_ra = {r_sel, r_i[IW-1:0]};
                    n_state = S_WEX;
                end else begin
                    if (!r_is_rem && !r_emitted) begin
                        emit = 1'b1; emit_d = {r_nlo, r_nhi};
                    end
                    n_state = S_KRD;
                end
            end
            S_WEX: begin
                if (!r_is_rem) begin
                    if (r_emitted) begin
                        emit = 1'b1; n_i = r_i + 1'b1; n_state = S_WRD;
                    end else if ({1'b0, e_hi} + 1'b1 < {1'b0, r_nlo}) begin
                        emit = 1'b1; n_i = r_i + 1'b1; n_state = S_WRD;
                    end else if ({1'b0, e_lo} <= {1'b0, r_nhi} + 1'b1) begin
                        if (e_lo < r_nlo) n_nlo = e_lo;
                        if (e_hi > r_nhi) n_nhi = e_hi;
                        n_i = r_i + 1'b1; n_state = S_WRD;
                    end else begin
                        emit = 1'b1; emit_d = {r_nlo, r_nhi}; n_emitted = 1'b1;
                    end
                end else begin
                    if (e_hi < r_lo || e_lo > r_hi) begin
                        emit = 1'b1; n_i = r_i + 1'b1; n_state = S_WRD;
                    end else if (!r_sub && e_lo < r_lo) begin
                        emit = 1'b1; emit_d = {e_lo, r_lo - 1'b1};
                        if (e_hi > r_hi) n_sub = 1'b1;
                        else begin
                            n_i = r_i + 1'b1; n_state = S_WRD;
                        end
                    end else begin
                        if (e_hi > r_hi) begin
                            emit = 1'b1; emit_d = {r_hi + 1'b1, e_hi};
                        end
                        n_sub = 1'b0; n_i = r_i + 1'b1; n_state = S_WRD;
                    end
                end
            end
            S_KRD: begin
                if (r_ovf) begin
                    n_full = 1'b1; n_state = S_DONE;
                end else if (r_k < r_n) begin
                    scr_re = 1'b1; n_state = S_KWR;
                end else begin
                    if (r_sel) n_cnt_b = r_n;
                    else n_cnt_a = r_n;
                    n_state = S_DONE;
                end
            end
            S_KWR: begin
                smem_we = 1'b1; smem_wa = {r_sel, r_k[IW-1:0]};
                n_k = r_k + 1'b1; n_state = S_KRD;
            end
            S_CCK: begin
                if (r_ia < r_cnt_a && r_ib < r_cnt_b) begin
                    if (r_need_a) n_state = S_CFA;
                    else if (r_need_b) n_state = S_CFB;
                    else n_state = S_CEV;
                end else begin
                    if (r_ia >= r_cnt_a && r_ib < r_cnt_b) nsup_f = 1'b1;
                    else if (r_ib >= r_cnt_b && r_ia < r_cnt_a) nsub_f = 1'b1;
                    if (r_disj) n_rel = ise_pkg::REL_DISJOINT;
                    else if (nsub_f && nsup_f) n_rel = ise_pkg::REL_OVERLAP;
                    else if (nsub_f) n_rel = ise_pkg::REL_SUPERSET;
                    else if (nsup_f) n_rel = ise_pkg::REL_SUBSET;
                    else n_rel = ise_pkg::REL_EQUIV;
                    n_state = S_DONE;
                end
            end
            S_CFA: begin
                smem_re = 1'b1; smem_ra = {1'b0, r_ia[IW-1:0]}; n_state = S_CWA;
            end
            S_CWA: begin
                n_al = e_lo; n_ah = e_hi; n_need_a = 1'b0; n_state = S_CCK;
            end
            S_CFB: begin
                smem_re = 1'b1; smem_ra = {1'b1, r_ib[IW-1:0]}; n_state = S_CWB;
            end
            S_CWB: begin
                n_bl = e_lo; n_bh = e_hi; n_need_b = 1'b0; n_state = S_CCK;
            end
            S_CEV: begin
                if (r_ah < r_bl) begin
                    n_ia = r_ia + 1'b1; n_nsub = 1'b1; n_need_a = 1'b1;
                end else if (r_bh < r_al) begin
                    n_ib = r_ib + 1'b1; n_nsup = 1'b1; n_need_b = 1'b1;
                end else begin
                    n_disj = 1'b0;
                    if (r_al < r_bl) n_nsub = 1'b1;
                    if (r_bl < r_al) n_nsup = 1'b1;
                    if (r_ah <= r_bh) begin
                        n_ia = r_ia + 1'b1; n_need_a = 1'b1;
                    end
                    if (r_bh <= r_ah) begin
                        n_ib = r_ib + 1'b1; n_need_b = 1'b1;
                    end
                end
                n_state = S_CCK;
            end
            S_DONE: begin
                if (!r_ovalid || m_tready) begin
                    n_odata = {5'd0, 7'(cur_n), r_full, r_rel};
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (emit) begin
            if (r_n < MAXC) begin
                scr_we = 1'b1; n_n = r_n + 1'b1;
            end else n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt_a <= '0; r_cnt_b <= '0; r_ovalid <= 1'b0;
            r_n <= '0; r_ovf <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt_a <= n_cnt_a; r_cnt_b <= n_cnt_b;
            r_ovalid <= n_ovalid; r_n <= n_n; r_ovf <= n_ovf;
        end
        r_is_rem <= n_is_rem; r_sel <= n_sel; r_lo <= n_lo; r_hi <= n_hi;
        r_nlo <= n_nlo; r_nhi <= n_nhi; r_i <= n_i; r_k <= n_k; r_ia <= n_ia;
        r_ib <= n_ib; r_emitted <= n_emitted; r_sub <= n_sub; r_need_a <= n_need_a;
        r_need_b <= n_need_b; r_al <= n_al; r_ah <= n_ah; r_bl <= n_bl; r_bh <= n_bh;
        r_nsub <= n_nsub; r_nsup <= n_nsup; r_disj <= n_disj; r_rel <= n_rel;
        r_full <= n_full; r_odata <= n_odata;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= MAXC && r_cnt_b <= MAXC) else $error("set count above capacity");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAXC) else $error("scratch fill above capacity");
    a_no_copy_on_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_KWR |-> !r_ovf) else $error("copy back after overflow");
    a_full_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata[3] |-> r_odata[2:0] == ise_pkg::REL_DISJOINT)
        else $error("full flag with a relation");
`endif
endmodule
`default_nettype wire
